@@ rtl/hole_list_fit_allocator_assert.svh @@
// Assertion macros for the hole-list allocator.
// Each check is clocked on i_clk and disabled while i_rst_n is low.
`ifndef HOLE_LIST_FIT_ALLOCATOR_ASSERT_SVH
`define HOLE_LIST_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define HLFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HLFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hlfa_pkg.sv @@
package hlfa_pkg;

    localparam int MAX_HOLES_DEF = 32;
    localparam int ADDR_BITS_DEF = 16;

    localparam int SIZE_W   = 16;
    localparam int RADDR_W  = 16;
    localparam int OADDR_W  = 16;
    localparam int STATUS_W = 2;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic POLICY_FIRST = 1'b0;
    localparam logic POLICY_BEST  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

@@ rtl/hole_list_fit_allocator.sv @@
// Hole-list allocator, first fit or best fit.
//
// Input channel (i_in_valid / o_in_stall): one item per request. i_action
// selects allocate or release; i_region_size is the word count and
// i_release_address the start of a released region.
// Output channel (o_out_valid / i_out_stall): exactly one item per request,
// o_status (ok, no fit, table full) and o_alloc_address.
// Config: i_cfg_we writes i_cfg_wdata into the fit policy (0 first fit,
// 1 best fit); write only while the block is idle.
// A nonzero-size item is scanned, then committed, then its result is
// loaded into the output register. The hole table sits in one
// single-port-read RAM, so the scan visits one entry per cycle, then a
// commit state writes the changed entry back. Zero-size items skip the
// scan and commit. One item is worked on at a time: the next item is taken
// only once the block is back in idle, after the result has been loaded.
// A finished result waits in the output register, and the next item is
// accepted and scanned meanwhile. If the receiver stalls, the block holds
// its next result, and the input, until the output frees.
// Reset clears the valid bits, hole count, policy and both channels; the RAM
// contents need no clearing since every entry is guarded by its valid bit.
module hole_list_fit_allocator #(
    parameter int MAX_HOLES = hlfa_pkg::MAX_HOLES_DEF,
    parameter int ADDR_BITS = hlfa_pkg::ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [hlfa_pkg::SIZE_W-1:0]   i_region_size,
    input  logic [hlfa_pkg::RADDR_W-1:0]  i_release_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hlfa_pkg::STATUS_W-1:0] o_status,
    output logic [hlfa_pkg::OADDR_W-1:0]  o_alloc_address
);

    `include "hole_list_fit_allocator_assert.svh"

    localparam int IDX_W = $clog2(MAX_HOLES);
    localparam int CNT_W = $clog2(MAX_HOLES + 1);
    // a hole may span the whole space, so lengths carry one extra bit
    localparam int LEN_W = ADDR_BITS + 1;
    localparam int CMP_W = (LEN_W > hlfa_pkg::SIZE_W) ? LEN_W : hlfa_pkg::SIZE_W;
    localparam int ENT_W = ADDR_BITS + LEN_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_RESULT
    } t_state;

    t_state r_state;

    logic                    r_fit_policy;
    logic [MAX_HOLES-1:0]    r_valid;
    logic [CNT_W-1:0]        r_hole_count;

    // request
    logic                    r_is_rel;
    logic [CMP_W-1:0]        r_size;

    // scan sequencing: r_cnt issues reads, r_pend marks data returning
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_pend;
    logic [IDX_W-1:0]        r_pidx;

    // allocate: best candidate so far
    logic                    r_found;
    logic [IDX_W-1:0]        r_best_idx;
    logic [ADDR_BITS-1:0]    r_best_start;
    logic [LEN_W-1:0]        r_best_len;

    // release: merged range and first free slot
    logic [ADDR_BITS-1:0]    r_lo;
    logic [LEN_W-1:0]        r_hi;
    logic                    r_slot_found;
    logic [IDX_W-1:0]        r_slot;

    // pending result
    hlfa_pkg::t_status       r_res_status;
    logic [hlfa_pkg::OADDR_W-1:0] r_res_addr;

    // output register
    logic                    r_out_valid;
    hlfa_pkg::t_status       r_status;
    logic [hlfa_pkg::OADDR_W-1:0] r_alloc_address;

    // RAM ports
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENT_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [ENT_W-1:0]        ram_rdata;

    hlfa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_HOLES)
    ) u_hole_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Accept-side decode of a release: mask address, clip at the top.
    // ---------------------------------------------------------------
    logic                    in_acc;
    logic [ADDR_BITS-1:0]    rel_addr;
    logic [LEN_W-1:0]        rel_room;
    logic [CMP_W-1:0]        rel_size_w;
    logic [LEN_W-1:0]        rel_len;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign rel_addr   = ADDR_BITS'(i_release_address);
    assign rel_room   = {1'b1, {ADDR_BITS{1'b0}}} - {1'b0, rel_addr};
    assign rel_size_w = CMP_W'(i_region_size);
    assign rel_len    = (rel_size_w > CMP_W'(rel_room)) ? rel_room : LEN_W'(rel_size_w);

    // ---------------------------------------------------------------
    // Per-entry evaluation of the word coming back from the RAM
    // ---------------------------------------------------------------
    logic [ADDR_BITS-1:0]    rd_start;
    logic [LEN_W-1:0]        rd_len;
    logic [LEN_W-1:0]        rd_end;
    logic                    rd_v;
    logic                    fits;
    logic                    better;
    logic                    touch;
    logic                    free_here;
    logic                    scan_done;

    assign rd_start  = ram_rdata[ENT_W-1 -: ADDR_BITS];
    assign rd_len    = ram_rdata[LEN_W-1:0];
    assign rd_end    = LEN_W'(rd_start) + rd_len;
    assign rd_v      = r_valid[r_pidx];

    assign fits      = rd_v && (CMP_W'(rd_len) >= r_size);
    assign better    = !r_found ||
                       ((r_fit_policy == hlfa_pkg::POLICY_BEST)
                        ? ((rd_len < r_best_len) ||
                           ((rd_len == r_best_len) && (rd_start < r_best_start)))
                        : (rd_start < r_best_start));

    // holes never touch each other, so growing the range while scanning
    // picks up the same holes as a test against the original region
    assign touch     = rd_v && (LEN_W'(rd_start) <= r_hi) && (rd_end >= LEN_W'(r_lo));
    assign free_here = !rd_v || touch;

    assign ram_re    = (r_state == S_SCAN) && (r_cnt < CNT_W'(MAX_HOLES));
    assign scan_done = (r_state == S_SCAN) && !ram_re && !r_pend;

    // ---------------------------------------------------------------
    // Write-back word
    // ---------------------------------------------------------------
    logic [LEN_W-1:0]        alloc_len_new;
    logic [ADDR_BITS-1:0]    alloc_start_new;

    assign alloc_len_new   = r_best_len - LEN_W'(r_size);
    assign alloc_start_new = ADDR_BITS'(LEN_W'(r_best_start) + LEN_W'(r_size));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_best_idx;
        ram_wdata = {alloc_start_new, alloc_len_new};
        if (r_state == S_COMMIT) begin
            if (r_is_rel) begin
                ram_we    = r_slot_found;
                ram_waddr = r_slot;
                ram_wdata = {r_lo, r_hi - LEN_W'(r_lo)};
            end else begin
                ram_we    = r_found;
            end
        end
    end

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // ---------------------------------------------------------------
    // Control, table bookkeeping and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fit_policy <= hlfa_pkg::POLICY_FIRST;
            r_valid      <= '0;
            r_hole_count <= '0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_slot_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fit_policy <= i_cfg_wdata;
            end

            // load a finished result, or drop the one just taken
            if ((r_state == S_RESULT) && out_free) begin
                r_out_valid     <= 1'b1;
                r_status        <= r_res_status;
                r_alloc_address <= r_res_addr;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_is_rel     <= (i_action == hlfa_pkg::ACT_RELEASE);
                        r_size       <= CMP_W'(i_region_size);
                        r_cnt        <= '0;
                        r_pend       <= 1'b0;
                        r_found      <= 1'b0;
                        r_slot_found <= 1'b0;
                        r_lo         <= rel_addr;
                        r_hi         <= LEN_W'(rel_addr) + rel_len;
                        r_res_status <= hlfa_pkg::ST_OK;
                        r_res_addr   <= '0;
                        // zero-size items change nothing
                        r_state      <= (i_region_size == '0) ? S_RESULT : S_SCAN;
                    end
                end

                S_SCAN: begin
                    r_pend <= ram_re;
                    r_pidx <= r_cnt[IDX_W-1:0];
                    if (ram_re) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_pend) begin
                        if (r_is_rel) begin
                            if (touch) begin
                                r_valid[r_pidx] <= 1'b0;
                                r_hole_count    <= r_hole_count - 1'b1;
                                if (LEN_W'(rd_start) < LEN_W'(r_lo)) begin
                                    r_lo <= rd_start;
                                end
                                if (rd_end > r_hi) begin
                                    r_hi <= rd_end;
                                end
                            end
                            if (free_here && !r_slot_found) begin
                                r_slot_found <= 1'b1;
                                r_slot       <= r_pidx;
                            end
                        end else if (fits && better) begin
                            r_found      <= 1'b1;
                            r_best_idx   <= r_pidx;
                            r_best_start <= rd_start;
                            r_best_len   <= rd_len;
                        end
                    end
                    if (scan_done) begin
                        r_state <= S_COMMIT;
                    end
                end

                S_COMMIT: begin
                    if (r_is_rel) begin
                        if (r_slot_found) begin
                            r_valid[r_slot] <= 1'b1;
                            r_hole_count    <= r_hole_count + 1'b1;
                        end else begin
                            r_res_status <= hlfa_pkg::ST_FULL;
                        end
                    end else if (r_found) begin
                        r_res_addr <= hlfa_pkg::OADDR_W'(r_best_start);
                        if (alloc_len_new == '0) begin
                            r_valid[r_best_idx] <= 1'b0;
                            r_hole_count        <= r_hole_count - 1'b1;
                        end
                    end else begin
                        r_res_status <= hlfa_pkg::ST_NOFIT;
                    end
                    r_state <= S_RESULT;
                end

                S_RESULT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_alloc_address = r_alloc_address;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `HLFA_ASSERT_NOW(a_count_tracks_valid, 1'b1,
        r_hole_count == CNT_W'($countones(r_valid)), "hole count disagrees with valid bits")
    `HLFA_ASSERT_NOW(a_slot_is_free, (r_state == S_COMMIT) && r_is_rel && r_slot_found,
        !r_valid[r_slot], "release slot still holds a live hole")
    `HLFA_ASSERT_NOW(a_full_only_when_full, (r_state == S_COMMIT) && r_is_rel && !r_slot_found,
        &r_valid, "table-full result with a free slot")
    `HLFA_ASSERT_NOW(a_pick_fits, (r_state == S_COMMIT) && !r_is_rel && r_found,
        CMP_W'(r_best_len) >= r_size, "chosen hole smaller than request")
    `HLFA_ASSERT_NEXT(a_accept_leaves_idle, in_acc,
        (r_state == S_SCAN) || (r_state == S_RESULT), "accepted item not started")

endmodule

@@ rtl/hlfa_ram.sv @@
module hlfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int          TABLE_DEPTH   = hlfa_pkg::MAX_HOLES_DEF;
    localparam int unsigned SPACE         = 1 << hlfa_pkg::ADDR_BITS_DEF;
    localparam int unsigned ADDR_MASK     = SPACE - 1;
    localparam int          SZ_W          = hlfa_pkg::SIZE_W;
    localparam int          RA_W          = hlfa_pkg::RADDR_W;
    localparam int          OA_W          = hlfa_pkg::OADDR_W;
    localparam int          ST_W          = hlfa_pkg::STATUS_W;
    // fill pattern: one small hole per stride, never touching its neighbors
    localparam int unsigned STRIDE        = SPACE / TABLE_DEPTH;
    localparam int          IDLE_PCT      = 12;
    localparam int          PHASES        = 6;
    localparam int          PHASE_ITEMS   = 225;
    // time for a nonzero-size item to finish, with some margin
    localparam int          SETTLE_CYCLES = hlfa_pkg::MAX_HOLES_DEF + 12;

    // one expected result, tagged with the index of the item that caused it
    typedef struct {
        hlfa_pkg::t_status    status;
        logic [OA_W-1:0]      addr;
        int                   seq;
    } t_grant;

    // a region handed out by the block, kept so it can be given back later
    typedef struct {
        logic [OA_W-1:0] base;
        logic [SZ_W-1:0] size;
    } t_region;

    // Hole table predictor plus the queue of results still owed by the block.
    class alloc_scoreboard;
        int unsigned base[TABLE_DEPTH];
        int unsigned span[TABLE_DEPTH];   // may reach SPACE, wider than an address
        bit          live[TABLE_DEPTH];
        int          live_total;
        bit          prefer_small;
        t_grant      pending[$];
        int          accepted;

        function hlfa_pkg::t_status take(int unsigned size, output logic [OA_W-1:0] addr);
            int pick;
            pick = -1;
            addr = '0;
            if (size == 0) return hlfa_pkg::ST_OK;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (!live[i] || span[i] < size) continue;
                if (pick < 0) begin
                    pick = i;
                end else if (prefer_small) begin
                    if (span[i] < span[pick] ||
                        (span[i] == span[pick] && base[i] < base[pick]))
                        pick = i;
                end else if (base[i] < base[pick]) begin
                    pick = i;
                end
            end
            if (pick < 0) return hlfa_pkg::ST_NOFIT;
            addr = base[pick][OA_W-1:0];
            base[pick] = (base[pick] + size) & ADDR_MASK;
            span[pick] -= size;
            if (span[pick] == 0) begin
                live[pick] = 1'b0;
                live_total--;
            end
            return hlfa_pkg::ST_OK;
        endfunction

        function hlfa_pkg::t_status give_back(int unsigned where, int unsigned size);
            int unsigned lo, hi, s, e, len;
            int          touching, slot;
            if (size == 0) return hlfa_pkg::ST_OK;
            lo  = where & ADDR_MASK;
            len = size;
            if (len > SPACE - lo) len = SPACE - lo;   // clip at the top
            hi  = lo + len;
            touching = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (live[i] && base[i] <= hi && base[i] + span[i] >= lo) touching++;
            if (touching == 0 && live_total >= TABLE_DEPTH) return hlfa_pkg::ST_FULL;
            // absorb every hole touching the growing union
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (!live[i]) continue;
                s = base[i];
                e = s + span[i];
                if (s <= hi && e >= lo) begin
                    if (s < lo) lo = s;
                    if (e > hi) hi = e;
                    live[i] = 1'b0;
                    live_total--;
                end
            end
            slot = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (!live[i]) begin
                    slot = i;
                    break;
                end
            end
            base[slot] = lo;
            span[slot] = hi - lo;
            live[slot] = 1'b1;
            live_total++;
            return hlfa_pkg::ST_OK;
        endfunction

        function t_grant note_input(logic act, logic [SZ_W-1:0] size,
                                    logic [RA_W-1:0] where);
            t_grant g;
            g.addr = '0;
            g.seq  = accepted++;
            if (act == hlfa_pkg::ACT_ALLOC) g.status = take(32'(size), g.addr);
            else                            g.status = give_back(32'(where), 32'(size));
            pending.insert(pending.size(), g);
            return g;
        endfunction

        function bit check_result(logic [ST_W-1:0] st, logic [OA_W-1:0] addr,
                                  output string why);
            t_grant g;
            if (pending.size() == 0) begin
                why = $sformatf("result with nothing pending: status %0d address %h",
                                st, addr);
                return 1'b0;
            end
            g   = pending.pop_front();
            why = "";
            if (st !== g.status)
                why = $sformatf("item %0d status %0d, expected %0d", g.seq, st, g.status);
            if (addr !== g.addr)
                why = $sformatf("%s item %0d address %h, expected %h",
                                why, g.seq, addr, g.addr);
            return why == "";
        endfunction

        function int unsigned smallest_hole();
            int unsigned m;
            m = SPACE + 1;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (live[i] && span[i] < m) m = span[i];
            return m;
        endfunction
    endclass

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_cfg_we          = 1'b0;
    logic                i_cfg_wdata       = 1'b0;
    logic                i_in_valid        = 1'b0;
    logic                o_in_stall;
    logic                i_action          = hlfa_pkg::ACT_ALLOC;
    logic [SZ_W-1:0]     i_region_size     = '0;
    logic [RA_W-1:0]     i_release_address = '0;
    logic                o_out_valid;
    logic                i_out_stall       = 1'b0;
    logic [ST_W-1:0]     o_status;
    logic [OA_W-1:0]     o_alloc_address;

    alloc_scoreboard sb = new();
    t_region         granted[$];   // regions currently held by the stimulus
    int              errors = 0;
    bit              steady = 1'b0; // set: neither side idles
    string           why;

    hole_list_fit_allocator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_region_size     (i_region_size),
        .i_release_address (i_release_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_alloc_address   (o_alloc_address)
    );

    always #5 i_clk = ~i_clk;

    task automatic report(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // receiver: random stalls except during the steady stretch
    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // outputs are read at the edge, before the block's own updates land
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (!sb.check_result(o_status, o_alloc_address, why)) report(why);
        end
    end

    // Present one item, hold it until accepted, then predict its result.
    // Called right after a rising edge; leaves valid high on return.
    task automatic send_item(logic act, logic [SZ_W-1:0] size,
                             logic [RA_W-1:0] where);
        t_grant  g;
        t_region held;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_action          <= act;
        i_region_size     <= size;
        i_release_address <= where;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        g = sb.note_input(act, size, where);
        if (act == hlfa_pkg::ACT_ALLOC && g.status == hlfa_pkg::ST_OK && size != 0) begin
            held.base = g.addr;
            held.size = size;
            granted.insert(granted.size(), held);
        end
    endtask

    // Sender holds off until every owed result has been taken.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_policy(logic p);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.prefer_small = p;
    endtask

    // Extremes, every action, and the corner cases of the hole table.
    task automatic directed_items();
        send_item(hlfa_pkg::ACT_ALLOC,   16'd100,  16'h0000);  // empty table, nothing fits
        send_item(hlfa_pkg::ACT_ALLOC,   16'd0,    16'hFFFF);  // zero-size allocate
        send_item(hlfa_pkg::ACT_RELEASE, 16'd0,    16'h1234);  // zero-size release
        send_item(hlfa_pkg::ACT_RELEASE, 16'h1000, 16'h1000);
        send_item(hlfa_pkg::ACT_RELEASE, 16'h0100, 16'h3000);
        send_item(hlfa_pkg::ACT_RELEASE, 16'hFFFF, 16'hFFF0);  // runs past the top, clipped
        send_item(hlfa_pkg::ACT_RELEASE, 16'h1000, 16'h2000);  // joins holes on both sides
        send_item(hlfa_pkg::ACT_RELEASE, 16'h0100, 16'h0F80);  // overlaps the front of a hole
        send_item(hlfa_pkg::ACT_RELEASE, 16'h0010, 16'h0040);
        send_item(hlfa_pkg::ACT_ALLOC,   16'h0010, 16'h0000);  // first fit: lowest address
        send_item(hlfa_pkg::ACT_ALLOC,   16'h0010, 16'hFFFF);
        send_item(hlfa_pkg::ACT_ALLOC,   16'hFFFF, 16'h0000);  // larger than any hole
        set_policy(hlfa_pkg::POLICY_BEST);
        send_item(hlfa_pkg::ACT_RELEASE, 16'h0020, 16'h8000);
        send_item(hlfa_pkg::ACT_RELEASE, 16'h0020, 16'h6000);  // same size as the one above
        send_item(hlfa_pkg::ACT_ALLOC,   16'h0008, 16'h0000);  // smallest fit is the top hole
        send_item(hlfa_pkg::ACT_ALLOC,   16'h0010, 16'h5555);  // tie goes to the lower address
        send_item(hlfa_pkg::ACT_ALLOC,   16'h0010, 16'hAAAA);
        send_item(hlfa_pkg::ACT_RELEASE, 16'hFFFF, 16'h0000);  // swallows every hole
        send_item(hlfa_pkg::ACT_RELEASE, 16'h0001, 16'hFFFF);  // whole space is one hole now
        send_item(hlfa_pkg::ACT_ALLOC,   16'hFFFF, 16'h0000);
        send_item(hlfa_pkg::ACT_ALLOC,   16'h0001, 16'h0000);  // empties the table
        send_item(hlfa_pkg::ACT_ALLOC,   16'h0001, 16'h0000);
        set_policy(hlfa_pkg::POLICY_FIRST);
    endtask

    // Best fit must be active: each exact-size grant removes one hole.
    task automatic drain_table();
        int unsigned len;
        while (sb.live_total > 0) begin
            len = sb.smallest_hole();
            if (len > 16'hFFFF) len = 16'hFFFF;
            send_item(hlfa_pkg::ACT_ALLOC, len[SZ_W-1:0], RA_W'($urandom));
        end
    endtask

    // Fill every slot with separated holes, then probe the full table.
    task automatic fill_table();
        int          j;
        int unsigned where;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            where = k * STRIDE + $urandom_range(0, STRIDE / 4);
            send_item(hlfa_pkg::ACT_RELEASE, SZ_W'($urandom_range(1, STRIDE / 2)),
                      where[RA_W-1:0]);
        end
        // clear of every hole: refused while the table is full
        where = $urandom_range(0, TABLE_DEPTH - 1) * STRIDE + STRIDE - 16;
        send_item(hlfa_pkg::ACT_RELEASE, 16'd8, where[RA_W-1:0]);
        send_item(hlfa_pkg::ACT_RELEASE, 16'hFFFF, 16'hFFFF);
        // touching the end of a hole still merges
        j     = $urandom_range(0, TABLE_DEPTH - 1);
        where = sb.base[j] + sb.span[j];
        send_item(hlfa_pkg::ACT_RELEASE, 16'd8, where[RA_W-1:0]);
        send_item(hlfa_pkg::ACT_ALLOC, 16'd4, RA_W'($urandom));
    endtask

    // Make the whole address space one hole, whatever the table holds.
    task automatic open_space();
        send_item(hlfa_pkg::ACT_RELEASE, 16'hFFFF, 16'h0000);
        send_item(hlfa_pkg::ACT_RELEASE, 16'hFFFF, 16'hFFFF);
    endtask

    // Mostly grants and returns of granted regions, the rest arbitrary releases.
    task automatic random_item();
        int                 r, k;
        logic [SZ_W-1:0]    size;
        t_region            chunk;
        r = $urandom_range(99);
        k = $urandom_range(99);
        if (r < 45) begin
            if (k < 70)      size = SZ_W'($urandom_range(1, 2048));
            else if (k < 85) size = SZ_W'($urandom_range(1, 64));
            else if (k < 95) size = SZ_W'($urandom);
            else             size = '0;
            send_item(hlfa_pkg::ACT_ALLOC, size, RA_W'($urandom));
        end else if (r < 82 && granted.size() > 0) begin
            k     = $urandom_range(0, granted.size() - 1);
            chunk = granted[k];
            granted.delete(k);
            send_item(hlfa_pkg::ACT_RELEASE, chunk.size, chunk.base);
        end else begin
            if (k < 55)      size = SZ_W'($urandom_range(1, 512));
            else if (k < 85) size = SZ_W'($urandom);
            else             size = '0;
            send_item(hlfa_pkg::ACT_RELEASE, size, RA_W'($urandom));
        end
    endtask

    initial begin
        logic p;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_policy(hlfa_pkg::POLICY_FIRST);
        directed_items();

        for (int phase = 0; phase < PHASES; phase++) begin
            steady = (phase == 2);
            granted.delete();
            if (phase % 3 == 0) begin
                set_policy(hlfa_pkg::POLICY_BEST);
                drain_table();
                fill_table();
            end else begin
                open_space();
            end
            // policy per phase: first, best, first, best, best, first
            p = (phase % 2 == 1) ^ (phase >= 4);
            set_policy(p);
            repeat (PHASE_ITEMS) random_item();
        end
        steady = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard, many times the slowest legal run
    initial begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
